// ----- sv/olds_pkg.sv -----
// Shared types and codes for the ordered list delete-successor block.
package olds_pkg;

  localparam int DATA_W = 32;

  // Result status codes
  localparam logic [2:0] ST_APPENDED     = 3'd0;
  localparam logic [2:0] ST_SUCCESSOR    = 3'd1;
  localparam logic [2:0] ST_NONE_GREATER = 3'd2;
  localparam logic [2:0] ST_EMPTY        = 3'd3;
  localparam logic [2:0] ST_BAD_POS      = 3'd4;
  localparam logic [2:0] ST_FULL         = 3'd5;

  // Input opcodes
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // Cell row operations
  localparam logic [1:0] CELL_HOLD   = 2'd0;
  localparam logic [1:0] CELL_SHIFT  = 2'd1;
  localparam logic [1:0] CELL_APPEND = 2'd2;

  typedef struct packed {
    logic [1:0] op;    // row operation for this cycle
    logic       wrap;  // tail cell takes the head value on a shift
  } cell_ctl_t;

endpackage

// ----- sv/olds_cell.sv -----
// One storage cell of the list row: holds an entry and shifts toward the head.
module olds_cell #(
  parameter int IDX_W = 6
) (
  input  logic                            clk,
  input  olds_pkg::cell_ctl_t             ctl,
  input  logic [IDX_W-1:0]                my_idx,
  input  logic [IDX_W-1:0]                tail_idx,
  input  logic [IDX_W-1:0]                wr_idx,
  input  logic signed [olds_pkg::DATA_W-1:0] right_val,
  input  logic signed [olds_pkg::DATA_W-1:0] head_val,
  input  logic signed [olds_pkg::DATA_W-1:0] in_val,
  output logic signed [olds_pkg::DATA_W-1:0] val
);
  import olds_pkg::*;

  logic signed [DATA_W-1:0] val_r;
  logic signed [DATA_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    case (ctl.op)
      CELL_APPEND: begin
        if (my_idx == wr_idx) val_nxt = in_val;
      end
      CELL_SHIFT: begin
        if (my_idx < tail_idx) begin
          val_nxt = right_val;
        end else if (my_idx == tail_idx && ctl.wrap) begin
          val_nxt = head_val;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

// ----- sv/olds_min.sv -----
// Running minimum of the values seen at the head that exceed a reference.
module olds_min (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               clear,
  input  logic                               en,
  input  logic signed [olds_pkg::DATA_W-1:0] ref_val,
  input  logic signed [olds_pkg::DATA_W-1:0] cand,
  output logic                               found,
  output logic signed [olds_pkg::DATA_W-1:0] best
);
  import olds_pkg::*;

  logic                     found_r, found_nxt;
  logic signed [DATA_W-1:0] best_r, best_nxt;
  logic                     take;

  assign take = en && (cand > ref_val) && (!found_r || cand < best_r);

  always_comb begin
    found_nxt = found_r;
    best_nxt  = best_r;
    if (clear) begin
      found_nxt = 1'b0;
    end else if (take) begin
      found_nxt = 1'b1;
      best_nxt  = cand;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
    best_r <= best_nxt;
  end

  assign found = found_r;
  assign best  = best_r;

endmodule

// ----- sv/ordered_list_delete_successor_core.sv -----
// Top level of the ordered list: cell row, successor search and control.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------------
//   in      | input     | in_valid / in_ready  | in_opcode, in_value, in_position
//   out     | output    | out_valid / out_ready| out_status, out_deleted_value,
//           |           |                      | out_next_greater
//
// Sequence: an append or a rejected delete is written to the output register
//   on its transfer. A good delete passes S_PASS1, S_PASS2 and S_DONE: the cell row
//   rotates the list once to fetch the removed entry at the head, then once
//   more while dropping that entry and feeding every survivor to the single
//   compare unit at the head.
// Reset: rst_n is synchronous, active low; it empties the list. Cell contents
//   are not cleared, only entries below the count are ever read.
// Stalls: one item is in work at a time; in_ready is high only while idle with
//   the output register free or draining. A finished delete waits for the slot.
module ordered_list_delete_successor_core #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_opcode,
  input  logic signed [olds_pkg::DATA_W-1:0] in_value,
  input  logic [5:0]                         in_position,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [2:0]                         out_status,
  output logic signed [olds_pkg::DATA_W-1:0] out_deleted_value,
  output logic signed [olds_pkg::DATA_W-1:0] out_next_greater
);
  import olds_pkg::*;

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CW    = $clog2(MAX_ENTRIES + 1);
  localparam int PW    = (CW > 6) ? CW : 6;

  // Control states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PASS1 = 2'd1;
  localparam logic [1:0] S_PASS2 = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]              state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [CW-1:0]           step_r, step_nxt;
  logic [CW-1:0]           len_r, len_nxt;
  logic [CW-1:0]           pos_r, pos_nxt;
  logic signed [DATA_W-1:0] removed_r, removed_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [2:0]               out_status_r, out_status_nxt;
  logic signed [DATA_W-1:0] out_del_r, out_del_nxt;
  logic signed [DATA_W-1:0] out_next_r, out_next_nxt;

  logic signed [DATA_W-1:0] cell_val [MAX_ENTRIES];
  logic signed [DATA_W-1:0] head_val;
  cell_ctl_t                ctl;
  logic [IDX_W-1:0]         tail_idx;
  logic [IDX_W-1:0]         wr_idx;

  logic           in_xfer;
  logic           out_free;
  logic           is_full;
  logic           pos_ok;
  logic           del_go;
  logic [CW-1:0]  count_m1;
  logic [CW-1:0]  len_m1;
  logic           last_step;
  logic           hit;
  logic           min_clear;
  logic           min_en;
  logic           min_found;
  logic signed [DATA_W-1:0] min_best;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign in_xfer   = in_valid && in_ready;
  assign is_full   = (count_r == CW'(MAX_ENTRIES));
  assign pos_ok    = PW'(in_position) < PW'(count_r);
  assign del_go    = in_xfer && (in_opcode == OP_DELETE) && (count_r != '0) && pos_ok;
  assign count_m1  = count_r - 1'b1;
  assign len_m1    = len_r - 1'b1;
  assign last_step = (step_r == count_m1);
  assign hit       = (step_r == pos_r);
  assign head_val  = cell_val[0];
  assign wr_idx    = count_r[IDX_W-1:0];

  // Row control: append writes at the tail, the passes rotate toward the head
  always_comb begin
    ctl.op   = CELL_HOLD;
    ctl.wrap = 1'b0;
    tail_idx = count_m1[IDX_W-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_xfer && in_opcode == OP_APPEND && !is_full) ctl.op = CELL_APPEND;
      end
      S_PASS1: begin
        ctl.op   = CELL_SHIFT;
        ctl.wrap = 1'b1;
      end
      S_PASS2: begin
        ctl.op   = CELL_SHIFT;
        ctl.wrap = !hit;           // drop the removed entry, recirculate the rest
        tail_idx = len_m1[IDX_W-1:0];
      end
      default: ctl.op = CELL_HOLD;
    endcase
  end

  for (genvar gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
    logic signed [DATA_W-1:0] right_val;
    if (gi == MAX_ENTRIES - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_mid
      assign right_val = cell_val[gi+1];
    end
    olds_cell #(
      .IDX_W (IDX_W)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .my_idx    (IDX_W'(gi)),
      .tail_idx  (tail_idx),
      .wr_idx    (wr_idx),
      .right_val (right_val),
      .head_val  (head_val),
      .in_val    (in_value),
      .val       (cell_val[gi])
    );
  end

  // Compare each survivor at the head against the removed value
  assign min_clear = del_go;
  assign min_en    = (state_r == S_PASS2) && !hit;

  olds_min u_min (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (min_clear),
    .en      (min_en),
    .ref_val (removed_r),
    .cand    (head_val),
    .found   (min_found),
    .best    (min_best)
  );

  // Sequencer and output register
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    step_nxt       = step_r;
    len_nxt        = len_r;
    pos_nxt        = pos_r;
    removed_nxt    = removed_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_del_nxt    = out_del_r;
    out_next_nxt   = out_next_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          out_del_nxt  = '0;
          out_next_nxt = '0;
          if (in_opcode == OP_APPEND) begin
            out_valid_nxt = 1'b1;
            if (is_full) begin
              out_status_nxt = ST_FULL;
            end else begin
              out_status_nxt = ST_APPENDED;
              count_nxt      = count_r + 1'b1;
            end
          end else if (count_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_EMPTY;
          end else if (!pos_ok) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_BAD_POS;
          end else begin
            pos_nxt   = CW'(PW'(in_position));
            step_nxt  = '0;
            state_nxt = S_PASS1;
          end
        end
      end
      S_PASS1: begin
        // capture the entry as it passes the head
        if (hit) removed_nxt = head_val;
        step_nxt = step_r + 1'b1;
        if (last_step) begin
          step_nxt  = '0;
          len_nxt   = count_r;
          state_nxt = S_PASS2;
        end
      end
      S_PASS2: begin
        if (hit) len_nxt = len_m1;
        step_nxt = step_r + 1'b1;
        if (last_step) begin
          count_nxt = count_m1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = min_found ? ST_SUCCESSOR : ST_NONE_GREATER;
          out_del_nxt    = removed_r;
          out_next_nxt   = min_found ? min_best : '0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    step_r       <= step_nxt;
    len_r        <= len_nxt;
    pos_r        <= pos_nxt;
    removed_r    <= removed_nxt;
    out_status_r <= out_status_nxt;
    out_del_r    <= out_del_nxt;
    out_next_r   <= out_next_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_deleted_value = out_del_r;
  assign out_next_greater  = out_next_r;

  // The list never grows past its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ENTRIES))
    else $error("list count above capacity");

  // A good delete always starts the first rotation
  a_del_start: assert property (@(posedge clk) disable iff (!rst_n)
    del_go |=> state_r == S_PASS1)
    else $error("delete did not start rotation");

  // A delete shrinks the list by exactly one when it completes
  a_del_shrink: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PASS2 && last_step) |=> count_r == $past(count_r) - 1'b1)
    else $error("delete did not shrink the list by one");

  // A successor result never reports a value at or below the removed one
  a_succ_gt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_SUCCESSOR) |-> out_next_greater > out_deleted_value)
    else $error("successor not above removed value");

endmodule
